// ===== rtl/aapct_pkg.sv =====
// ----------------------------------------------------------------------------
// aapct_pkg
// Shared types and codes of the rectangle pair collision tracker: request
// opcodes, event kinds and the stored rectangle entry.
// ----------------------------------------------------------------------------
package aapct_pkg;

    // request opcodes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_SCAN  = 1'b1;

    // event kinds on the result port
    localparam logic [1:0] EV_ENTER = 2'd0;
    localparam logic [1:0] EV_EXIT  = 2'd1;
    localparam logic [1:0] EV_NONE  = 2'd2;

    // one stored rectangle, 60 bits
    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [11:0]        w;
        logic [11:0]        h;
        logic [3:0]         grp;
    } rect_t;

endpackage

// ===== rtl/aabb_pair_collision_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// aabb_pair_collision_tracker_unit
// Table of up to MAX_COLLIDERS rectangles with a pairwise overlap scan that
// reports enter and exit events against stored per-pair collision flags.
// ----------------------------------------------------------------------------
//
//  channel   handshake              payload
//  -------   ---------------------  ---------------------------------------------
//  request   start / busy           op, slot, pos_x, pos_y, width, height, group_id
//  result    result_valid (strobe)  event_kind, self_slot, other_slot, last
//
//  a request is taken on a rising edge with start high and busy low
//  write: busy stays low, the none result appears the next cycle
//  scan: busy until it closes, one row load per row plus one pair test per cycle
//  through the shared overlap unit
//  results are single-cycle strobes, the receiver cannot stall them
//  reset clears slot valid bits and all pair flags at once, no clearing pass
//
module aabb_pair_collision_tracker_unit
    import aapct_pkg::*;
#(
    parameter int MAX_COLLIDERS = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               op,
    input  logic [2:0]         slot,
    input  logic signed [15:0] pos_x,
    input  logic signed [15:0] pos_y,
    input  logic [11:0]        width,
    input  logic [11:0]        height,
    input  logic [3:0]         group_id,
    output logic               result_valid,
    output logic [1:0]         event_kind,
    output logic [2:0]         self_slot,
    output logic [2:0]         other_slot,
    output logic               last
);

    localparam int IDX_W = (MAX_COLLIDERS > 1) ? $clog2(MAX_COLLIDERS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_COLLIDERS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_PAIR,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;

    rect_t      rect_table [MAX_COLLIDERS];
    rect_t      self_reg, self_next;
    rect_t      rd_rect;
    logic [IDX_W-1:0] rd_idx;

    logic [MAX_COLLIDERS-1:0] valid_reg, valid_next;
    logic [MAX_COLLIDERS-1:0] coll_reg [MAX_COLLIDERS];
    logic [MAX_COLLIDERS-1:0] coll_next [MAX_COLLIDERS];

    logic [IDX_W-1:0] s_reg, s_next;
    logic [IDX_W-1:0] o_reg, o_next;

    logic             pend_valid_reg, pend_valid_next;
    logic [1:0]       pend_kind_reg, pend_kind_next;
    logic [IDX_W-1:0] pend_s_reg, pend_s_next;
    logic [IDX_W-1:0] pend_o_reg, pend_o_next;

    logic       out_valid_reg, out_valid_next;
    logic [1:0] out_kind_reg, out_kind_next;
    logic [2:0] out_s_reg, out_s_next;
    logic [2:0] out_o_reg, out_o_next;
    logic       out_last_reg, out_last_next;

    logic accept;
    logic wr_ok;
    logic [IDX_W-1:0] wr_idx;

    logic signed [16:0] sx, sy, ox, oy, sw, sh, ow, oh;
    logic hit, pair_live, had;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);
    assign wr_ok  = ({1'b0, slot} < 4'(MAX_COLLIDERS));
    assign wr_idx = slot[IDX_W-1:0];

    // single table read port, self row on load, other slot during the pair walk
    assign rd_idx  = (state_reg == ST_LOAD) ? s_reg : o_reg;
    assign rd_rect = rect_table[rd_idx];

    // shared overlap unit: four 17-bit add and compare lanes
    assign sx = {self_reg.x[15], self_reg.x};
    assign sy = {self_reg.y[15], self_reg.y};
    assign ox = {rd_rect.x[15], rd_rect.x};
    assign oy = {rd_rect.y[15], rd_rect.y};
    assign sw = $signed({5'd0, self_reg.w});
    assign sh = $signed({5'd0, self_reg.h});
    assign ow = $signed({5'd0, rd_rect.w});
    assign oh = $signed({5'd0, rd_rect.h});

    assign hit = (sx < (ox + ow)) && (ox < (sx + sw)) &&
                 (sy < (oy + oh)) && (oy < (sy + sh));

    // pair is tested unless same slot, an empty slot or a shared nonzero group
    assign pair_live = (o_reg != s_reg) && valid_reg[s_reg] && valid_reg[o_reg] &&
                       !((self_reg.grp != 4'd0) && (self_reg.grp == rd_rect.grp));
    assign had = coll_reg[s_reg][o_reg];

    // rectangle storage, no reset
    always_ff @(posedge clk)
    begin
        if (accept && (op == OP_WRITE) && wr_ok)
        begin
            rect_table[wr_idx] <= '{x: pos_x, y: pos_y, w: width, h: height,
                                    grp: group_id};
        end
    end

    // sequencer next state
    always_comb
    begin
        state_next      = state_reg;
        self_next       = self_reg;
        valid_next      = valid_reg;
        coll_next       = coll_reg;
        s_next          = s_reg;
        o_next          = o_reg;
        pend_valid_next = pend_valid_reg;
        pend_kind_next  = pend_kind_reg;
        pend_s_next     = pend_s_reg;
        pend_o_next     = pend_o_reg;
        out_valid_next  = 1'b0;
        out_kind_next   = out_kind_reg;
        out_s_next      = out_s_reg;
        out_o_next      = out_o_reg;
        out_last_next   = out_last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (op == OP_WRITE)
                    begin
                        if (wr_ok)
                        begin
                            valid_next[wr_idx] = 1'b1;
                        end
                        out_valid_next = 1'b1;
                        out_kind_next  = EV_NONE;
                        out_s_next     = 3'd0;
                        out_o_next     = 3'd0;
                        out_last_next  = 1'b1;
                    end
                    else
                    begin
                        s_next          = '0;
                        o_next          = '0;
                        pend_valid_next = 1'b0;
                        state_next      = ST_LOAD;
                    end
                end
            end

            ST_LOAD:
            begin
                self_next  = rd_rect;
                o_next     = '0;
                state_next = ST_PAIR;
            end

            ST_PAIR:
            begin
                // a change of state is held back one event so last can be marked
                if (pair_live && (hit != had))
                begin
                    coll_next[s_reg][o_reg] = hit;
                    if (pend_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_kind_next  = pend_kind_reg;
                        out_s_next     = 3'(pend_s_reg);
                        out_o_next     = 3'(pend_o_reg);
                        out_last_next  = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_kind_next  = hit ? EV_ENTER : EV_EXIT;
                    pend_s_next     = s_reg;
                    pend_o_next     = o_reg;
                end
                if (o_reg == LAST_IDX)
                begin
                    if (s_reg == LAST_IDX)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        s_next     = s_reg + IDX_W'(1);
                        state_next = ST_LOAD;
                    end
                end
                else
                begin
                    o_next = o_reg + IDX_W'(1);
                end
            end

            ST_DONE:
            begin
                out_valid_next = 1'b1;
                out_last_next  = 1'b1;
                if (pend_valid_reg)
                begin
                    out_kind_next = pend_kind_reg;
                    out_s_next    = 3'(pend_s_reg);
                    out_o_next    = 3'(pend_o_reg);
                end
                else
                begin
                    out_kind_next = EV_NONE;
                    out_s_next    = 3'd0;
                    out_o_next    = 3'd0;
                end
                pend_valid_next = 1'b0;
                state_next      = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state, flags and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            valid_reg      <= '0;
            for (int i = 0; i < MAX_COLLIDERS; i++)
            begin
                coll_reg[i] <= '0;
            end
            s_reg          <= '0;
            o_reg          <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            coll_reg       <= coll_next;
            s_reg          <= s_next;
            o_reg          <= o_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        self_reg      <= self_next;
        pend_kind_reg <= pend_kind_next;
        pend_s_reg    <= pend_s_next;
        pend_o_reg    <= pend_o_next;
        out_kind_reg  <= out_kind_next;
        out_s_reg     <= out_s_next;
        out_o_reg     <= out_o_next;
        out_last_reg  <= out_last_next;
    end

    assign result_valid = out_valid_reg;
    assign event_kind   = out_kind_reg;
    assign self_slot    = out_s_reg;
    assign other_slot   = out_o_reg;
    assign last         = out_last_reg;

    // end of a scan always delivers the closing result
    a_scan_close: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> (result_valid && last))
        else $error("scan ended without a closing result");

    // a write gives exactly one none result on the next cycle
    a_write_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (op == OP_WRITE)) |=>
            (result_valid && last && (event_kind == EV_NONE)))
        else $error("write request without its none result");

    // a none result only ever closes a request
    a_none_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (event_kind == EV_NONE)) |-> last)
        else $error("none result not marked last");

    // events never pair a slot with itself
    a_distinct: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (event_kind != EV_NONE)) |-> (self_slot != other_slot))
        else $error("event reports a slot against itself");

    // no closing result while a scan is still walking pairs
    a_no_early_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PAIR) |=> !(result_valid && last))
        else $error("last result before the scan finished");

endmodule
